>>> sv/lser_pkg.sv
// ----------------------------------------------------------------------------
// lser_pkg
// Shared types, constants and helpers for the LED status effect renderer.
// ----------------------------------------------------------------------------
package lser_pkg;

    // Frame size and LED index width
    localparam int LedCount = 8;
    localparam int IdxW     = $clog2(LedCount);

    // Display modes, in priority order
    typedef enum logic [2:0] {
        ModeError   = 3'd0,
        ModeBooting = 3'd1,
        ModeOffline = 3'd2,
        ModeConfig  = 3'd3,
        ModeReady   = 3'd4
    } t_mode;

    // One LED color
    typedef struct packed {
        logic [4:0] r;
        logic [4:0] g;
        logic [4:0] b;
    } t_rgb;

    localparam t_rgb BootBase  = '{r: 5'd16, g: 5'd10, b: 5'd0};
    localparam t_rgb CfgBase   = '{r: 5'd0,  g: 5'd3,  b: 5'd16};
    localparam t_rgb ReadyRgb  = '{r: 5'd0,  g: 5'd10, b: 5'd2};
    localparam t_rgb BlackRgb  = '{r: 5'd0,  g: 5'd0,  b: 5'd0};
    localparam logic [4:0] ChanMax = 5'd16;

    // Flow head: time / 160 = (time >> 5) / 5, divide by reciprocal
    localparam int FlowShift    = 5;
    localparam int FlowDiv      = 5;
    localparam int FlowRecipSh  = 29;
    localparam logic [26:0] FlowRecip =
        27'(((64'd1 << FlowRecipSh) + FlowDiv - 1) / FlowDiv);

    // Head modulo the LED count, divide by reciprocal
    localparam int ModRecipSh = 31;
    localparam logic [31:0] ModRecip =
        32'(((64'd1 << ModRecipSh) + LedCount - 1) / LedCount);

    // Breathing: time mod 1600 = 64 * ((time >> 6) mod 25) + (time & 63)
    localparam int BreathPeriod  = 1600;
    localparam int BreathHalf    = BreathPeriod / 2;
    localparam int BreathDiv     = 25;
    localparam int BreathRecipSh = 31;
    localparam logic [26:0] BreathRecip =
        27'(((64'd1 << BreathRecipSh) + BreathDiv - 1) / BreathDiv);
    localparam logic [4:0] BreathFloor = 5'd3;
    // Small divide by five for values up to 63
    localparam logic [9:0] FiveRecip   = 10'd13;

    // Blink: time mod 600 = 8 * ((time >> 3) mod 75) + (time & 7)
    localparam int BlinkPeriod  = 600;
    localparam int BlinkHalf    = BlinkPeriod / 2;
    localparam int BlinkDiv     = 75;
    localparam int BlinkRecipSh = 36;
    localparam logic [29:0] BlinkRecip =
        30'(((64'd1 << BlinkRecipSh) + BlinkDiv - 1) / BlinkDiv);

    // Tail brightness in percent for head, one behind, two behind
    localparam int PctFull = 100;
    localparam int TailPct [3] = '{100, 44, 18};

    // Flow colors by tap: 0 head, 1 and 2 tail, 3 dark
    localparam t_rgb BootFlow [4] = '{
        '{r: 5'(32'(BootBase.r) * TailPct[0] / PctFull),
          g: 5'(32'(BootBase.g) * TailPct[0] / PctFull),
          b: 5'(32'(BootBase.b) * TailPct[0] / PctFull)},
        '{r: 5'(32'(BootBase.r) * TailPct[1] / PctFull),
          g: 5'(32'(BootBase.g) * TailPct[1] / PctFull),
          b: 5'(32'(BootBase.b) * TailPct[1] / PctFull)},
        '{r: 5'(32'(BootBase.r) * TailPct[2] / PctFull),
          g: 5'(32'(BootBase.g) * TailPct[2] / PctFull),
          b: 5'(32'(BootBase.b) * TailPct[2] / PctFull)},
        BlackRgb
    };

    localparam t_rgb CfgFlow [4] = '{
        '{r: 5'(32'(CfgBase.r) * TailPct[0] / PctFull),
          g: 5'(32'(CfgBase.g) * TailPct[0] / PctFull),
          b: 5'(32'(CfgBase.b) * TailPct[0] / PctFull)},
        '{r: 5'(32'(CfgBase.r) * TailPct[1] / PctFull),
          g: 5'(32'(CfgBase.g) * TailPct[1] / PctFull),
          b: 5'(32'(CfgBase.b) * TailPct[1] / PctFull)},
        '{r: 5'(32'(CfgBase.r) * TailPct[2] / PctFull),
          g: 5'(32'(CfgBase.g) * TailPct[2] / PctFull),
          b: 5'(32'(CfgBase.b) * TailPct[2] / PctFull)},
        BlackRgb
    };

endpackage

>>> sv/led_status_effect_renderer.sv
// ----------------------------------------------------------------------------
// led_status_effect_renderer
// Renders one frame of LED colors per status request.
//
// Input channel: i_valid / o_stall with four status flags and a millisecond
// time. A request is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall, one result per LED, index 0 to
// LED count minus one, the last marked by o_frame_end.
// The first LED of a frame passes the input register, two reciprocal
// multiply stages, a modulo stage, the frame stage and the output register.
// Throughput: one LED per cycle while the receiver does not stall, set by
// the frame stage that walks the LED counter. Requests queue in the four
// earlier stages while a frame is being sent.
// Reset clears all valid bits and the LED counter; nothing is in flight.
// When the receiver stalls, the output register holds its result, the
// frame stage holds its place and the stall backs up stage by stage to
// o_stall.
// ----------------------------------------------------------------------------
module led_status_effect_renderer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_is_booting,
    input  logic        i_usb_up,
    input  logic        i_in_config,
    input  logic        i_fault,
    input  logic [31:0] i_time_ms,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_shown_mode,
    output logic [5:0]  o_led_index,
    output logic [4:0]  o_led_red,
    output logic [4:0]  o_led_green,
    output logic [4:0]  o_led_blue,
    output logic        o_frame_end
);

    localparam int IdxW = lser_pkg::IdxW;

    typedef struct packed {
        logic        boot;
        logic        usb;
        logic        cfg;
        logic        err;
        logic [31:0] t;
    } t_s0;

    typedef struct packed {
        lser_pkg::t_mode mode;
        logic [53:0]     p_flow;
        logic [52:0]     p_br;
        logic [58:0]     p_bl;
        logic [10:0]     t_lo;
    } t_s1;

    typedef struct packed {
        lser_pkg::t_mode   mode;
        logic [IdxW-1:0]   q_lo;
        logic [IdxW-1:0]   q2_lo;
        logic [4:0]        br_red;
        logic [4:0]        br_grn;
        logic              blink_on;
    } t_s2;

    typedef struct packed {
        lser_pkg::t_mode   mode;
        logic [IdxW-1:0]   head;
        logic [4:0]        br_red;
        logic [4:0]        br_grn;
        logic              blink_on;
    } t_s3;

    logic r_v0, r_v1, r_v2, r_v3, r_f_valid, r_out_valid;
    t_s0  r_s0;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    t_s3  r_frame;
    logic [IdxW-1:0] r_led;

    logic [2:0] r_out_mode;
    logic [5:0] r_out_idx;
    lser_pkg::t_rgb r_out_rgb, n_rgb;
    logic r_out_end;

    logic out_free, emit, f_last, f_ready, rdy3, rdy2, rdy1, rdy0;

    // Handshake: stall backs up from the output register
    assign out_free = !r_out_valid || !i_stall;
    assign emit     = r_f_valid && out_free;
    assign f_last   = (r_led == IdxW'(lser_pkg::LedCount - 1));
    assign f_ready  = !r_f_valid || (emit && f_last);
    assign rdy3     = !r_v3 || f_ready;
    assign rdy2     = !r_v2 || rdy3;
    assign rdy1     = !r_v1 || rdy2;
    assign rdy0     = !r_v0 || rdy1;
    assign o_stall  = !rdy0;

    // Stage 1: mode select and the three reciprocal multiplies
    always_comb begin
        if (r_s0.err) begin
            n_s1.mode = lser_pkg::ModeError;
        end else if (r_s0.boot) begin
            n_s1.mode = lser_pkg::ModeBooting;
        end else if (!r_s0.usb) begin
            n_s1.mode = lser_pkg::ModeOffline;
        end else if (r_s0.cfg) begin
            n_s1.mode = lser_pkg::ModeConfig;
        end else begin
            n_s1.mode = lser_pkg::ModeReady;
        end
        n_s1.p_flow = 54'(r_s0.t[31:5]) * 54'(lser_pkg::FlowRecip);
        n_s1.p_br   = 53'(r_s0.t[31:6]) * 53'(lser_pkg::BreathRecip);
        n_s1.p_bl   = 59'(r_s0.t[31:3]) * 59'(lser_pkg::BlinkRecip);
        n_s1.t_lo   = r_s0.t[10:0];
    end

    // Stage 2: head modulo multiply, breathing level, blink phase
    logic [24:0] q_flow;
    logic [56:0] p_mod;
    logic [21:0] br_q;
    logic [4:0]  br_rem;
    logic [10:0] br_ph, br_tri;
    logic [9:0]  br_div;
    logic [22:0] bl_q;
    logic [6:0]  bl_rem;
    logic [9:0]  bl_ph;

    always_comb begin
        q_flow = r_s1.p_flow[53:29];
        p_mod  = 57'(q_flow) * 57'(lser_pkg::ModRecip);

        br_q   = r_s1.p_br[52:31];
        br_rem = r_s1.t_lo[10:6] - 5'(32'(br_q) * lser_pkg::BreathDiv);
        br_ph  = {br_rem, r_s1.t_lo[5:0]};
        br_tri = (br_ph <= 11'(lser_pkg::BreathHalf)) ? br_ph
                                                      : 11'(lser_pkg::BreathPeriod) - br_ph;
        // tri * 10 / 800 = (tri >> 4) / 5
        br_div = {4'b0, br_tri[9:4]} * lser_pkg::FiveRecip;

        bl_q   = r_s1.p_bl[58:36];
        bl_rem = r_s1.t_lo[9:3] - 7'(32'(bl_q) * lser_pkg::BlinkDiv);
        bl_ph  = {bl_rem, r_s1.t_lo[2:0]};

        n_s2.mode     = r_s1.mode;
        n_s2.q_lo     = q_flow[IdxW-1:0];
        n_s2.q2_lo    = p_mod[lser_pkg::ModRecipSh +: IdxW];
        n_s2.br_red   = lser_pkg::BreathFloor + {1'b0, br_div[9:6]};
        n_s2.br_grn   = (n_s2.br_red + 5'd2) >> 2;
        n_s2.blink_on = (bl_ph < 10'(lser_pkg::BlinkHalf));
    end

    // Stage 3: head = q - floor(q / N) * N, low bits suffice
    always_comb begin
        n_s3.mode     = r_s2.mode;
        n_s3.head     = r_s2.q_lo - IdxW'(32'(r_s2.q2_lo) * lser_pkg::LedCount);
        n_s3.br_red   = r_s2.br_red;
        n_s3.br_grn   = r_s2.br_grn;
        n_s3.blink_on = r_s2.blink_on;
    end

    // Frame stage: color of the current LED
    logic [IdxW:0] behind_sum, behind;
    logic [1:0]    tap;

    always_comb begin
        behind_sum = {1'b0, r_led} + (IdxW+1)'(lser_pkg::LedCount) - {1'b0, r_frame.head};
        behind     = (behind_sum >= (IdxW+1)'(lser_pkg::LedCount))
                   ? behind_sum - (IdxW+1)'(lser_pkg::LedCount) : behind_sum;
        tap        = (behind < (IdxW+1)'(3)) ? behind[1:0] : 2'd3;

        unique case (r_frame.mode)
            lser_pkg::ModeBooting: n_rgb = lser_pkg::BootFlow[tap];
            lser_pkg::ModeConfig:  n_rgb = lser_pkg::CfgFlow[tap];
            lser_pkg::ModeOffline: n_rgb = '{r: r_frame.br_red, g: r_frame.br_grn, b: 5'd0};
            lser_pkg::ModeReady:   n_rgb = lser_pkg::ReadyRgb;
            default: begin
                n_rgb   = lser_pkg::BlackRgb;
                n_rgb.r = r_frame.blink_on ? lser_pkg::ChanMax : 5'd0;
            end
        endcase
    end

    // Pipeline valid bits and frame counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_f_valid   <= 1'b0;
            r_led       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy0) r_v0 <= i_valid;
            if (rdy1) r_v1 <= r_v0;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (f_ready) begin
                r_f_valid <= r_v3;
                r_led     <= '0;
            end else if (emit) begin
                r_led <= r_led + IdxW'(1);
            end
            if (out_free) r_out_valid <= emit;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_s0 <= '{boot: i_is_booting, usb: i_usb_up, cfg: i_in_config,
                      err: i_fault, t: i_time_ms};
        end
        if (rdy1)    r_s1    <= n_s1;
        if (rdy2)    r_s2    <= n_s2;
        if (rdy3)    r_s3    <= n_s3;
        if (f_ready) r_frame <= r_s3;
        if (emit) begin
            r_out_mode <= r_frame.mode;
            r_out_idx  <= 6'(r_led);
            r_out_rgb  <= n_rgb;
            r_out_end  <= f_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_shown_mode = r_out_mode;
    assign o_led_index  = r_out_idx;
    assign o_led_red    = r_out_rgb.r;
    assign o_led_green  = r_out_rgb.g;
    assign o_led_blue   = r_out_rgb.b;
    assign o_frame_end  = r_out_end;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED status effect renderer. Status requests
// are queued up front and fed by a bursty driver. A monitor under a
// changing stall pattern compares every LED of every frame with a frame
// predicted from the request's flags and time.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          PeriodHalf   = 4;
    localparam int          ResetCycles  = 4;
    localparam int          RandomReqs   = 280;
    localparam int          CycleLimit   = 200000;
    localparam int          HoldCycles   = 300;
    localparam int          HoldAtResult = 640;
    localparam int          TailCycles   = 40;
    localparam int          ReportMax    = 10;

    // Animation constants
    localparam int unsigned FlowStepMs   = 160;
    localparam int unsigned BreathMs     = 1600;
    localparam int unsigned BlinkMs      = 600;
    localparam int unsigned PctHead      = 100;
    localparam int unsigned PctNear      = 44;
    localparam int unsigned PctFar       = 18;
    localparam int unsigned ChanFull     = 16;

    // One status request
    typedef struct {
        logic        boot;
        logic        usb;
        logic        cfg;
        logic        fault;
        logic [31:0] stamp;
        bit          drain_first;   // wait for all LEDs before offering
    } t_status_req;

    // One rendered LED
    typedef struct {
        lser_pkg::t_mode mode;
        logic [5:0]      idx;
        logic [4:0]      red;
        logic [4:0]      green;
        logic [4:0]      blue;
        logic            last;
    } t_led_px;

    typedef enum int {StallNone, StallLight, StallHeavy, StallToggle} t_stall_style;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        i_is_booting = 1'b0;
    logic        i_usb_up     = 1'b0;
    logic        i_in_config  = 1'b0;
    logic        i_fault      = 1'b0;
    logic [31:0] i_time_ms    = '0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_shown_mode;
    logic [5:0]  o_led_index;
    logic [4:0]  o_led_red;
    logic [4:0]  o_led_green;
    logic [4:0]  o_led_blue;
    logic        o_frame_end;

    t_status_req  status_q[$];
    t_led_px      led_expect_q[$];
    t_status_req  req_on_bus;
    int           mismatches = 0;
    int           leds_seen  = 0;
    int           cycles     = 0;
    int           burst_left = 0;
    int           gap_left   = 0;
    int           hold_left  = 0;
    bit           hold_done  = 1'b0;
    int           style_left = 0;
    t_stall_style stall_style = StallNone;

    led_status_effect_renderer u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_is_booting (i_is_booting),
        .i_usb_up     (i_usb_up),
        .i_in_config  (i_in_config),
        .i_fault      (i_fault),
        .i_time_ms    (i_time_ms),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_shown_mode (o_shown_mode),
        .o_led_index  (o_led_index),
        .o_led_red    (o_led_red),
        .o_led_green  (o_led_green),
        .o_led_blue   (o_led_blue),
        .o_frame_end  (o_frame_end)
    );

    // Clock
    always begin
        #PeriodHalf i_clk = 1'b1;
        #PeriodHalf i_clk = 1'b0;
    end

    // Frame prediction: mode by priority, then one color per LED
    function automatic void render_frame(input t_status_req rq);
        lser_pkg::t_mode mode;
        int unsigned head;
        int unsigned behind;
        int unsigned pct;
        int unsigned phase;
        int unsigned ramp;
        int unsigned red;
        int unsigned base_r;
        int unsigned base_g;
        int unsigned base_b;
        int          led;
        t_led_px     px;
        if (rq.fault) begin
            mode = lser_pkg::ModeError;
        end else if (rq.boot) begin
            mode = lser_pkg::ModeBooting;
        end else if (!rq.usb) begin
            mode = lser_pkg::ModeOffline;
        end else if (rq.cfg) begin
            mode = lser_pkg::ModeConfig;
        end else begin
            mode = lser_pkg::ModeReady;
        end
        // running head: booting is amber, config is blue
        if (mode == lser_pkg::ModeBooting) begin
            base_r = ChanFull; base_g = 10; base_b = 0;
        end else begin
            base_r = 0; base_g = 3; base_b = ChanFull;
        end
        head = (rq.stamp / FlowStepMs) % lser_pkg::LedCount;
        for (led = 0; led < lser_pkg::LedCount; led++) begin
            px.mode  = mode;
            px.idx   = 6'(led);
            px.red   = '0;
            px.green = '0;
            px.blue  = '0;
            px.last  = (led == lser_pkg::LedCount - 1);
            case (mode)
                lser_pkg::ModeBooting, lser_pkg::ModeConfig: begin
                    behind = (led + lser_pkg::LedCount - head) % lser_pkg::LedCount;
                    pct = (behind == 0) ? PctHead :
                          (behind == 1) ? PctNear :
                          (behind == 2) ? PctFar  : 0;
                    px.red   = 5'(base_r * pct / 100);
                    px.green = 5'(base_g * pct / 100);
                    px.blue  = 5'(base_b * pct / 100);
                end
                lser_pkg::ModeOffline: begin
                    // triangle over the breathing period
                    phase = rq.stamp % BreathMs;
                    ramp  = (phase <= BreathMs / 2) ? phase : BreathMs - phase;
                    red   = 3 + ramp * 10 / (BreathMs / 2);
                    px.red   = 5'(red);
                    px.green = 5'((red + 2) / 4);
                end
                lser_pkg::ModeReady: begin
                    px.green = 5'd10;
                    px.blue  = 5'd2;
                end
                default: begin
                    px.red = ((rq.stamp % BlinkMs) < BlinkMs / 2) ? 5'(ChanFull) : 5'd0;
                end
            endcase
            led_expect_q.push_back(px);
        end
    endfunction

    function automatic void queue_status(input logic boot, input logic usb, input logic cfg,
                                         input logic fault, input logic [31:0] stamp,
                                         input bit drain_first);
        t_status_req rq;
        rq.boot        = boot;
        rq.usb         = usb;
        rq.cfg         = cfg;
        rq.fault       = fault;
        rq.stamp       = stamp;
        rq.drain_first = drain_first;
        status_q.push_back(rq);
    endfunction

    task automatic note_mismatch(input string what, input longint want_v, input longint got_v);
        mismatches++;
        if (mismatches <= ReportMax) begin
            $display("MISMATCH %s at LED result %0d: expected %0d, got %0d",
                     what, leds_seen, want_v, got_v);
        end
    endtask

    // Driver: bursts of requests with random gaps, optional drain before a request
    always @(posedge i_clk) begin
        logic        take;
        t_status_req rq;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            take = i_valid && !o_stall;
            if (take) begin
                render_frame(req_on_bus);
            end
            if (i_valid && !take) begin
                // stalled: hold the request as it is
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (status_q.size() == 0 ||
                         (status_q[0].drain_first && led_expect_q.size() != 0)) begin
                i_valid <= 1'b0;
            end else begin
                rq = status_q.pop_front();
                req_on_bus   = rq;
                i_valid      <= 1'b1;
                i_is_booting <= rq.boot;
                i_usb_up     <= rq.usb;
                i_in_config  <= rq.cfg;
                i_fault      <= rq.fault;
                i_time_ms    <= rq.stamp;
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
        end
    end

    // Monitor: compare each LED with the oldest prediction
    always @(posedge i_clk) begin
        t_led_px want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (led_expect_q.size() == 0) begin
                note_mismatch("unexpected LED index", -1, o_led_index);
            end else begin
                want = led_expect_q.pop_front();
                if (o_shown_mode !== want.mode) note_mismatch("mode", want.mode, o_shown_mode);
                if (o_led_index !== want.idx)   note_mismatch("index", want.idx, o_led_index);
                if (o_led_red !== want.red)     note_mismatch("red", want.red, o_led_red);
                if (o_led_green !== want.green) note_mismatch("green", want.green, o_led_green);
                if (o_led_blue !== want.blue)   note_mismatch("blue", want.blue, o_led_blue);
                if (o_frame_end !== want.last)  note_mismatch("frame end", want.last, o_frame_end);
            end
            leds_seen++;
        end
    end

    // Receiver stall: changing pattern plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (!hold_done && leds_seen >= HoldAtResult) begin
                hold_done = 1'b1;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (style_left == 0) begin
                    stall_style = t_stall_style'($urandom_range(0, 3));
                    style_left  = $urandom_range(20, 120);
                end else begin
                    style_left--;
                end
                case (stall_style)
                    StallNone:   i_stall <= 1'b0;
                    StallLight:  i_stall <= ($urandom_range(0, 3) == 0);
                    StallHeavy:  i_stall <= ($urandom_range(0, 9) < 6);
                    default:     i_stall <= ~i_stall;
                endcase
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("Timeout after %0d cycles, %0d LEDs still expected",
                     cycles, led_expect_q.size());
            $display("led_status_effect_renderer test failed");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        t_status_req rq;
        int          n;
        int          pick;
        logic [3:0]  flags;

        // fault blinks, any other flags ignored
        queue_status(0, 1, 0, 1, 32'd0, 0);
        queue_status(0, 1, 0, 1, 32'd299, 0);
        queue_status(0, 1, 0, 1, 32'd300, 0);
        queue_status(1, 0, 1, 1, 32'hFFFF_FFFF, 0);
        // booting flow: head at LED 0 so the tail wraps, then head steps
        queue_status(1, 1, 0, 0, 32'd0, 0);
        queue_status(1, 1, 0, 0, 32'd159, 0);
        queue_status(1, 1, 0, 0, 32'd160, 0);
        queue_status(1, 0, 0, 0, 32'd1279, 0);
        queue_status(1, 0, 0, 0, 32'd1280, 0);
        queue_status(1, 1, 1, 0, 32'hFFFF_FFFF, 0);
        // offline breathing: floor, peak and both slopes
        queue_status(0, 0, 0, 0, 32'd0, 0);
        queue_status(0, 0, 0, 0, 32'd800, 0);
        queue_status(0, 0, 0, 0, 32'd801, 1);
        queue_status(0, 0, 0, 0, 32'd1599, 0);
        queue_status(0, 0, 0, 0, 32'd1600, 0);
        queue_status(0, 0, 1, 0, 32'd400, 0);
        // config flow
        queue_status(0, 1, 1, 0, 32'd320, 0);
        queue_status(0, 1, 1, 0, 32'd0, 0);
        queue_status(0, 1, 1, 0, 32'hFFFF_FFFF, 0);
        // ready, across a time wrap
        queue_status(0, 1, 0, 0, 32'hFFFF_FFFF, 0);
        queue_status(0, 1, 0, 0, 32'd0, 0);
        queue_status(0, 1, 0, 0, 32'd12345, 0);

        // random requests, weighted over the modes; one in ten keeps its random flags
        for (n = 0; n < RandomReqs; n++) begin
            flags = 4'($urandom);
            {rq.boot, rq.usb, rq.cfg, rq.fault} = flags;
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1: rq.fault = 1'b1;
                2, 3: begin
                    rq.fault = 1'b0; rq.boot = 1'b1;
                end
                4, 5: begin
                    rq.fault = 1'b0; rq.boot = 1'b0; rq.usb = 1'b0;
                end
                6, 7: begin
                    rq.fault = 1'b0; rq.boot = 1'b0; rq.usb = 1'b1; rq.cfg = 1'b1;
                end
                8: begin
                    rq.fault = 1'b0; rq.boot = 1'b0; rq.usb = 1'b1; rq.cfg = 1'b0;
                end
                default: ;
            endcase
            case ($urandom_range(0, 5))
                0: rq.stamp = $urandom;
                1: rq.stamp = $urandom_range(0, 5000);
                2: rq.stamp = 32'hFFFF_FFFF - $urandom_range(0, 2000);
                3: rq.stamp = $urandom_range(0, 100000) * FlowStepMs + $urandom_range(0, 2) - 1;
                4: rq.stamp = $urandom_range(0, 100000) * (BlinkMs / 2) + $urandom_range(0, 2) - 1;
                default: rq.stamp = $urandom_range(0, 100000) * (BreathMs / 2)
                                    + $urandom_range(0, 2) - 1;
            endcase
            rq.drain_first = (n == RandomReqs * 3 / 4);
            status_q.push_back(rq);
        end

        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (status_q.size() != 0 || i_valid) @(posedge i_clk);
        while (led_expect_q.size() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);

        if (mismatches == 0 && led_expect_q.size() == 0) begin
            $display("led_status_effect_renderer test passed");
        end else begin
            $display("led_status_effect_renderer test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/lser_pkg.sv
sv/led_status_effect_renderer.sv
tb/tb_top.sv
